/* rtl/core/terminal_character_grid_unit_assert.svh */
// Assertion macros for the terminal character grid unit
`ifndef TERMINAL_CHARACTER_GRID_UNIT_ASSERT_SVH
`define TERMINAL_CHARACTER_GRID_UNIT_ASSERT_SVH

// check under reset gating
`define TCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also holds through reset
`define TCG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/tcg_pkg.sv */
// Shared types and constants of the terminal character grid unit
package tcg_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 128;
    localparam int TAB_DEF  = 8;

    localparam int ROWS_RST = 24;
    localparam int COLS_RST = 80;

    localparam int MODE_W  = 4;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CP_W    = 21;
    localparam int COLOR_W = 8;
    localparam int LINES_W = 6;
    localparam int KIND_W  = 2;
    localparam int AROWS_W = 6;
    localparam int ACOLS_W = 8;
    localparam int CFG_W   = 8;
    localparam int CELL_W  = CP_W + 2 * COLOR_W + 3;
    localparam int CMPW    = 10;

    localparam logic [CP_W-1:0]   BLANK_CP   = CP_W'(32);
    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_CP, {(CELL_W - CP_W){1'b0}}};

    typedef enum logic [0:0] {
        CFG_ACTIVE_ROWS,
        CFG_ACTIVE_COLS
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT, MODE_NL, MODE_CR, MODE_BS, MODE_TAB, MODE_RI, MODE_MOVE,
        MODE_SET, MODE_GET, MODE_CLEAR, MODE_CLROW, MODE_SU, MODE_SD,
        MODE_ED, MODE_EL
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_SU_WALK, S_SD_TOP, S_SD_WALK, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PLAN_DONE, PLAN_WALK, PLAN_SCROLL_UP, PLAN_SCROLL_DN
    } t_plan;

    typedef struct packed {
        logic accept_en;
        logic ld_in;
        logic exec;
        logic walk_step;
        logic row0_ld;
        logic top_inc;
        logic top_dec;
        logic cnt_dec;
        logic clr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_plan plan;
        logic  walk_last;
        logic  cnt_one;
        logic  clr_last;
        logic  out_free;
    } t_stat;

endpackage

/* rtl/core/tcg_ram.sv */
// Generic single-write, single-read RAM with registered read data
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tcg_ctrl.sv */
// Command sequencer of the terminal character grid unit
module tcg_ctrl import tcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_cfg_we,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_st.plan)
                    PLAN_DONE:      n_state = S_DONE;
                    PLAN_WALK:      n_state = S_WALK;
                    PLAN_SCROLL_UP: n_state = S_SU_WALK;
                    PLAN_SCROLL_DN: n_state = S_SD_TOP;
                    default:        n_state = S_DONE;
                endcase
            end
            S_WALK: begin
                if (i_st.walk_last) n_state = S_DONE;
            end
            S_SU_WALK: begin
                if (i_st.walk_last && i_st.cnt_one) n_state = S_DONE;
            end
            S_SD_TOP: begin
                n_state = S_SD_WALK;
            end
            S_SD_WALK: begin
                if (i_st.walk_last) n_state = i_st.cnt_one ? S_DONE : S_SD_TOP;
            end
            S_DONE: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        if (i_cfg_we) n_state = S_CLEAR;
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.accept_en = 1'b1;
                o_cmd.ld_in     = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            S_SU_WALK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.top_inc   = i_st.walk_last;
                o_cmd.cnt_dec   = i_st.walk_last;
                o_cmd.row0_ld   = i_st.walk_last;
            end
            S_SD_TOP: begin
                o_cmd.top_dec = 1'b1;
                o_cmd.row0_ld = 1'b1;
            end
            S_SD_WALK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.cnt_dec   = i_st.walk_last;
            end
            S_DONE: begin
                o_cmd.out_load = i_st.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/core/tcg_dpath.sv */
// Datapath of the terminal character grid unit: cursor, ring offset, cell store, result
module tcg_dpath import tcg_pkg::*; #(
    parameter int MAX_ROWS  = ROWS_DEF,
    parameter int MAX_COLS  = COLS_DEF,
    parameter int TAB_WIDTH = TAB_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_st,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_col,
    input  logic [CP_W-1:0]    i_codepoint,
    input  logic [COLOR_W-1:0] i_fg_color,
    input  logic [COLOR_W-1:0] i_bg_color,
    input  logic               i_bold,
    input  logic               i_italic,
    input  logic               i_underline,
    input  logic [LINES_W-1:0] i_line_count,
    input  logic [KIND_W-1:0]  i_erase_kind,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [ROW_W-1:0]   o_cursor_y,
    output logic [COL_W-1:0]   o_cursor_x,
    output logic [CP_W-1:0]    o_cell_codepoint,
    output logic [COLOR_W-1:0] o_cell_fg,
    output logic [COLOR_W-1:0] o_cell_bg,
    output logic               o_cell_bold,
    output logic               o_cell_italic,
    output logic               o_cell_underline,
    output logic               o_cell_dirty
);

    `include "terminal_character_grid_unit_assert.svh"

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TABS  = MAX_COLS / TAB_WIDTH + 1;
    localparam int RST_R = (ROWS_RST > MAX_ROWS) ? MAX_ROWS : ROWS_RST;
    localparam int RST_C = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;

    function automatic logic [CMPW-1:0] tab_stop(input logic [CW-1:0] col);
        logic [CMPW-1:0] res;
        res = CMPW'(TABS * TAB_WIDTH);
        for (int k = TABS; k >= 1; k--) begin
            if (CMPW'(k * TAB_WIDTH) > CMPW'(col)) res = CMPW'(k * TAB_WIDTH);
        end
        return res;
    endfunction

    logic [NRW-1:0]     r_nrows;
    logic [NCW-1:0]     r_ncols;
    logic [RW-1:0]      r_top;
    logic [RW-1:0]      r_cur_row, n_cur_row;
    logic [CW-1:0]      r_cur_col, n_cur_col;
    t_mode              r_mode;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [CELL_W-1:0]  r_cell;
    logic [LINES_W-1:0] r_lines, r_cnt, n_cnt;
    logic [KIND_W-1:0]  r_kind;
    logic [RW-1:0]      r_wr, r_er, n_wr, n_er;
    logic [CW-1:0]      r_wc, r_ec, n_wc, n_ec;
    logic               r_get_hit;
    logic [AW-1:0]      r_clr_cnt;
    logic               r_out_valid;
    logic [ROW_W-1:0]   r_cursor_y;
    logic [COL_W-1:0]   r_cursor_x;
    logic [CELL_W-1:0]  r_res_cell;
    logic               r_res_dirty;

    t_plan              plan;
    logic [RW-1:0]      last_row;
    logic [CW-1:0]      last_col;
    logic               in_rng;
    logic               row_rng;
    logic [CMPW-1:0]    tab_col;
    logic [RW-1:0]      ar;
    logic [CW-1:0]      ac;
    logic [RW:0]        psum;
    logic [RW-1:0]      prow;
    logic [AW-1:0]      addr;
    logic               ram_we;
    logic               ram_re;
    logic [CELL_W-1:0]  ram_wdata;
    logic [CELL_W-1:0]  ram_rdata;
    logic [CMPW-1:0]    cfg_rows;
    logic [CMPW-1:0]    cfg_cols;

    assign last_row = RW'(r_nrows - NRW'(1));
    assign last_col = CW'(r_ncols - NCW'(1));
    assign row_rng  = CMPW'(r_row) < CMPW'(r_nrows);
    assign in_rng   = row_rng && (CMPW'(r_col) < CMPW'(r_ncols));
    assign tab_col  = tab_stop(r_cur_col);

    assign cfg_rows = CMPW'(i_cfg_data[AROWS_W-1:0]);
    assign cfg_cols = CMPW'(i_cfg_data[ACOLS_W-1:0]);

    always_comb begin
        plan      = PLAN_DONE;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_cnt     = LINES_W'(1);
        n_wr      = '0;
        n_wc      = '0;
        n_er      = last_row;
        n_ec      = last_col;
        unique case (r_mode)
            MODE_PUT, MODE_NL: begin
                if (r_mode == MODE_PUT && r_cur_col != last_col) begin
                    n_cur_col = CW'(r_cur_col + 1'b1);
                end else begin
                    n_cur_col = (r_mode == MODE_PUT) ? '0 : r_cur_col;
                    if (r_cur_row == last_row) begin
                        plan = PLAN_SCROLL_UP;
                        n_er = '0;
                    end else begin
                        n_cur_row = RW'(r_cur_row + 1'b1);
                    end
                end
            end
            MODE_CR: n_cur_col = '0;
            MODE_BS: begin
                if (r_cur_col != '0) n_cur_col = CW'(r_cur_col - 1'b1);
            end
            MODE_TAB: begin
                n_cur_col = (tab_col < CMPW'(last_col)) ? CW'(tab_col) : last_col;
            end
            MODE_RI: begin
                if (r_cur_row == '0) begin
                    plan = PLAN_SCROLL_DN;
                    n_er = '0;
                end else begin
                    n_cur_row = RW'(r_cur_row - 1'b1);
                end
            end
            MODE_MOVE: begin
                n_cur_row = row_rng ? RW'(r_row) : last_row;
                n_cur_col = (CMPW'(r_col) < CMPW'(r_ncols)) ? CW'(r_col) : last_col;
            end
            MODE_SET, MODE_GET: plan = PLAN_DONE;
            MODE_CLEAR: begin
                plan      = PLAN_WALK;
                n_cur_row = '0;
                n_cur_col = '0;
            end
            MODE_CLROW: begin
                if (row_rng) begin
                    plan = PLAN_WALK;
                    n_wr = RW'(r_row);
                    n_er = RW'(r_row);
                end
            end
            MODE_SU, MODE_SD: begin
                n_cnt = r_lines;
                n_er  = '0;
                if (r_lines != '0) plan = (r_mode == MODE_SU) ? PLAN_SCROLL_UP : PLAN_SCROLL_DN;
            end
            MODE_ED: begin
                plan = PLAN_WALK;
                case (r_kind)
                    2'd0: begin
                        n_wr = r_cur_row;
                        n_wc = r_cur_col;
                    end
                    2'd1: begin
                        n_er = r_cur_row;
                        n_ec = r_cur_col;
                    end
                    default: n_wr = '0;
                endcase
            end
            MODE_EL: begin
                n_wr = r_cur_row;
                n_er = r_cur_row;
                case (r_kind)
                    2'd0: begin
                        plan = PLAN_WALK;
                        n_wc = r_cur_col;
                    end
                    2'd1: begin
                        plan = PLAN_WALK;
                        n_ec = r_cur_col;
                    end
                    2'd2: plan = PLAN_WALK;
                    default: plan = PLAN_DONE;
                endcase
            end
            default: plan = PLAN_DONE;
        endcase
    end

    always_comb begin
        if (i_cmd.walk_step) begin
            ar = r_wr;
            ac = r_wc;
        end else if (r_mode == MODE_PUT) begin
            ar = r_cur_row;
            ac = r_cur_col;
        end else begin
            ar = RW'(r_row);
            ac = CW'(r_col);
        end
        psum = (RW + 1)'(r_top) + (RW + 1)'(ar);
        if (psum >= (RW + 1)'(r_nrows)) begin
            prow = RW'(psum - (RW + 1)'(r_nrows));
        end else begin
            prow = RW'(psum);
        end
        if (i_cmd.clr_step) begin
            addr = r_clr_cnt;
        end else begin
            addr = AW'(prow * MAX_COLS) + AW'(ac);
        end
    end

    assign ram_we = i_cmd.clr_step || i_cmd.walk_step ||
                    (i_cmd.exec && (r_mode == MODE_PUT || (r_mode == MODE_SET && in_rng)));
    assign ram_re = i_cmd.exec && r_mode == MODE_GET && in_rng;
    assign ram_wdata = (i_cmd.clr_step || i_cmd.walk_step) ? BLANK_CELL : r_cell;

    tcg_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrows     <= NRW'(RST_R);
            r_ncols     <= NCW'(RST_C);
            r_top       <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ACTIVE_ROWS) begin
                r_nrows <= (cfg_rows == '0) ? NRW'(1) :
                           (cfg_rows > CMPW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(cfg_rows);
            end else begin
                r_ncols <= (cfg_cols == '0) ? NCW'(1) :
                           (cfg_cols > CMPW'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cfg_cols);
            end
            r_top     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= AW'(r_clr_cnt + 1'b1);
            if (i_cmd.exec) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
            end
            if (i_cmd.top_inc) begin
                r_top <= (r_top == last_row) ? '0 : RW'(r_top + 1'b1);
            end else if (i_cmd.top_dec) begin
                r_top <= (r_top == '0) ? last_row : RW'(r_top - 1'b1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_mode  <= t_mode'(i_mode);
            r_row   <= i_row;
            r_col   <= i_col;
            r_cell  <= {i_codepoint, i_fg_color, i_bg_color, i_bold, i_italic, i_underline};
            r_lines <= i_line_count;
            r_kind  <= i_erase_kind;
        end
        if (i_cmd.exec) begin
            r_cnt     <= n_cnt;
            r_wr      <= n_wr;
            r_wc      <= n_wc;
            r_er      <= n_er;
            r_ec      <= n_ec;
            r_get_hit <= in_rng;
        end else if (i_cmd.row0_ld) begin
            r_wr <= '0;
            r_wc <= '0;
            r_er <= '0;
            r_ec <= last_col;
        end else if (i_cmd.walk_step) begin
            if (r_wc == last_col) begin
                r_wc <= '0;
                r_wr <= RW'(r_wr + 1'b1);
            end else begin
                r_wc <= CW'(r_wc + 1'b1);
            end
        end
        if (i_cmd.cnt_dec) r_cnt <= LINES_W'(r_cnt - 1'b1);
        if (i_cmd.out_load) begin
            r_cursor_y <= ROW_W'(r_cur_row);
            r_cursor_x <= COL_W'(r_cur_col);
            if (r_mode == MODE_GET) begin
                r_res_cell  <= r_get_hit ? ram_rdata : BLANK_CELL;
                r_res_dirty <= 1'b1;
            end else begin
                r_res_cell  <= BLANK_CELL;
                r_res_dirty <= 1'b0;
            end
        end
    end

    assign o_st.plan      = plan;
    assign o_st.walk_last = (r_wr == r_er) && (r_wc == r_ec);
    assign o_st.cnt_one   = r_cnt == LINES_W'(1);
    assign o_st.clr_last  = r_clr_cnt == AW'(DEPTH - 1);
    assign o_st.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_cursor_y       = r_cursor_y;
    assign o_cursor_x       = r_cursor_x;
    assign o_cell_codepoint = r_res_cell[CELL_W-1 -: CP_W];
    assign o_cell_fg        = r_res_cell[2 * COLOR_W + 2 -: COLOR_W];
    assign o_cell_bg        = r_res_cell[COLOR_W + 2 -: COLOR_W];
    assign o_cell_bold      = r_res_cell[2];
    assign o_cell_italic    = r_res_cell[1];
    assign o_cell_underline = r_res_cell[0];
    assign o_cell_dirty     = r_res_dirty;

    `TCG_ASSERT(a_cursor_in_area, (CMPW'(r_cur_row) < CMPW'(r_nrows)) && (CMPW'(r_cur_col) < CMPW'(r_ncols)), "cursor left active area")
    `TCG_ASSERT(a_top_in_ring, CMPW'(r_top) < CMPW'(r_nrows), "ring offset out of range")
    `TCG_ASSERT(a_out_from_load, $rose(r_out_valid) |-> $past(i_cmd.out_load), "word shown without load")

endmodule

/* rtl/core/terminal_character_grid_unit.sv */
// Top level of the terminal character grid unit
// An accepted command is registered, executed and its result word loaded; no new command is
// taken before that load. Erase, clear and clear row blank one cell per walk step; each line of
// scroll up, scroll down or top reverse index blanks one row. A put at the last cell or a
// newline on the bottom row scrolls one line; a held result word stalls the next command.
// Reset and any register write sweep the whole store, input stalled.
module terminal_character_grid_unit import tcg_pkg::*; #(
    parameter int MAX_ROWS  = ROWS_DEF,
    parameter int MAX_COLS  = COLS_DEF,
    parameter int TAB_WIDTH = TAB_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_col,
    input  logic [CP_W-1:0]    i_codepoint,
    input  logic [COLOR_W-1:0] i_fg_color,
    input  logic [COLOR_W-1:0] i_bg_color,
    input  logic               i_bold,
    input  logic               i_italic,
    input  logic               i_underline,
    input  logic [LINES_W-1:0] i_line_count,
    input  logic [KIND_W-1:0]  i_erase_kind,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ROW_W-1:0]   o_cursor_y,
    output logic [COL_W-1:0]   o_cursor_x,
    output logic [CP_W-1:0]    o_cell_codepoint,
    output logic [COLOR_W-1:0] o_cell_fg,
    output logic [COLOR_W-1:0] o_cell_bg,
    output logic               o_cell_bold,
    output logic               o_cell_italic,
    output logic               o_cell_underline,
    output logic               o_cell_dirty
);

    t_cmd  cmd;
    t_stat st;

    assign o_in_stall = !cmd.accept_en;

    tcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tcg_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_codepoint      (i_codepoint),
        .i_fg_color       (i_fg_color),
        .i_bg_color       (i_bg_color),
        .i_bold           (i_bold),
        .i_italic         (i_italic),
        .i_underline      (i_underline),
        .i_line_count     (i_line_count),
        .i_erase_kind     (i_erase_kind),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_cursor_y       (o_cursor_y),
        .o_cursor_x       (o_cursor_x),
        .o_cell_codepoint (o_cell_codepoint),
        .o_cell_fg        (o_cell_fg),
        .o_cell_bg        (o_cell_bg),
        .o_cell_bold      (o_cell_bold),
        .o_cell_italic    (o_cell_italic),
        .o_cell_underline (o_cell_underline),
        .o_cell_dirty     (o_cell_dirty)
    );

endmodule
